// ----- hw/rtl/frp_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// frp_pkg
// Shared types and constants for the LED grayscale frame packer.
// ---------------------------------------------------------------------------
package frp_pkg;

    // Default configuration
    localparam int CHANNELS_DEF      = 24;
    localparam int FRAME_BYTES_DEF   = 36;
    localparam int LEVEL_MAX_DEF     = 4095;
    localparam int REPEAT_FRAMES_DEF = 2;

    // Level and digit geometry: a 12-bit level moves as three 4-bit nibbles
    localparam int LEVEL_W      = 12;
    localparam int DIGIT_W      = 4;
    localparam int LEVEL_DIGITS = 3;
    localparam int DIGIT_CNT_W  = 2;

    // Input opcodes
    localparam logic OP_SET  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Top-level sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WRITE,
        ST_PRIME,
        ST_EMIT
    } state_t;

    // Control from the sequencer to the nibble writer
    typedef struct packed {
        logic load;
        logic run;
    } wr_ctl_t;

    // Write strobe from the nibble writer: enable and nibble bank (0 = high)
    typedef struct packed {
        logic en;
        logic bank;
    } wr_port_t;

    // Control from the sequencer to the byte reader
    typedef struct packed {
        logic prime;
        logic emit;
    } rd_ctl_t;

endpackage

// ----- hw/rtl/frp_ram.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// frp_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module frp_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 36
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hw/rtl/frp_writer.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// frp_writer
// Nibble-serial channel writer: saturates a level, finds the channel's
// first nibble in the frame and shifts three nibbles out, one per cycle.
// ---------------------------------------------------------------------------
module frp_writer #(
    parameter int CHANNELS    = 24,
    parameter int FRAME_BYTES = 36,
    parameter int LEVEL_MAX   = 4095
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  frp_pkg::wr_ctl_t               ctl,
    input  logic [4:0]                     channel,
    input  logic [15:0]                    level,
    output frp_pkg::wr_port_t              wr,
    output logic [$clog2(FRAME_BYTES)-1:0] waddr,
    output logic [3:0]                     wdata,
    output logic                           done
);

    import frp_pkg::*;

    localparam int BYTE_AW = $clog2(FRAME_BYTES);
    localparam int NIB_LIM = (3 * CHANNELS > 2 * FRAME_BYTES) ? 3 * CHANNELS
                                                              : 2 * FRAME_BYTES;
    localparam int NIB_W   = $clog2(NIB_LIM + 3);

    logic [LEVEL_W-1:0]     shift_reg, shift_next;
    logic [NIB_W-1:0]       nib_reg, nib_next;
    logic [DIGIT_CNT_W-1:0] cnt_reg, cnt_next;
    logic [NIB_W-1:0]       rank;
    logic [NIB_W-1:0]       rank3;
    logic [NIB_W-1:0]       nib_start;
    logic [LEVEL_W-1:0]     level_sat;
    logic                   in_frame;

    // Saturate the requested level
    assign level_sat = (level > 16'(LEVEL_MAX)) ? LEVEL_W'(LEVEL_MAX) : level[LEVEL_W-1:0];

    // First nibble: twice the first byte, plus one when the channel is even
    assign rank      = NIB_W'(CHANNELS - 1) - NIB_W'(channel);
    assign rank3     = (rank << 1) + rank;
    assign nib_start = {rank3[NIB_W-1:1], ~channel[0]};

    // Nibble shift register and position counter
    always_comb
    begin
        shift_next = shift_reg;
        nib_next   = nib_reg;
        cnt_next   = cnt_reg;
        if (ctl.load)
        begin
            shift_next = level_sat;
            nib_next   = nib_start;
            cnt_next   = '0;
        end
        else if (ctl.run)
        begin
            shift_next = {shift_reg[LEVEL_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
            nib_next   = nib_reg + 1'b1;
            cnt_next   = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        nib_reg   <= nib_next;
    end

    // Nibbles past the end of the frame are dropped
    assign in_frame = nib_reg < NIB_W'(2 * FRAME_BYTES);
    assign wr.en    = ctl.run && in_frame;
    assign wr.bank  = nib_reg[0];
    assign waddr    = nib_reg[BYTE_AW:1];
    assign wdata    = shift_reg[LEVEL_W-1 -: DIGIT_W];
    assign done     = ctl.run && (cnt_reg == DIGIT_CNT_W'(LEVEL_DIGITS - 1));

endmodule

// ----- hw/rtl/frp_reader.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// frp_reader
// Frame byte reader: walks the byte index, presents the read address in the
// cycle before its byte is due and holds it while the output is stalled.
// ---------------------------------------------------------------------------
module frp_reader #(
    parameter int FRAME_BYTES = 36
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  frp_pkg::rd_ctl_t               ctl,
    input  logic                           out_stall,
    output logic [$clog2(FRAME_BYTES)-1:0] rd_addr,
    output logic                           last,
    output logic                           done
);

    import frp_pkg::*;

    localparam int BYTE_AW = $clog2(FRAME_BYTES);

    logic [BYTE_AW-1:0] idx_reg, idx_next;
    logic               beat;

    assign beat = ctl.emit && !out_stall;
    assign last = ctl.emit && (idx_reg == BYTE_AW'(FRAME_BYTES - 1));
    assign done = beat && last;

    // Next read address: advance on a beat, else hold for a stable payload
    assign rd_addr = (beat && !last) ? idx_reg + 1'b1 : idx_reg;

    // Byte index
    always_comb
    begin
        idx_next = idx_reg;
        if (ctl.prime)
        begin
            idx_next = '0;
        end
        else if (beat)
        begin
            idx_next = last ? '0 : idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

endmodule

// ----- hw/rtl/led_grayscale_frame_packer_core.sv -----
`timescale 1ns / 1ps
// Channel write: input stalled while the writer puts out the three nibbles, then idle again.
// Frame tick with frames pending: input stalled, a priming state, then FRAME_BYTES bytes
// at one per cycle while out_stall is low, with last_byte on the final byte.
// Frame tick with nothing pending: taken with no output.
// Reset: pending count zero and all nibble valid bits cleared, so the frame
// reads as zero; RAM contents are not swept.
// ---------------------------------------------------------------------------
// led_grayscale_frame_packer_core
// Grayscale frame store for 24 x 12-bit LED channels, packed MSB first,
// written nibble-serially and streamed out a byte per beat on frame ticks.
// ---------------------------------------------------------------------------
module led_grayscale_frame_packer_core #(
    parameter int CHANNELS      = frp_pkg::CHANNELS_DEF,
    parameter int FRAME_BYTES   = frp_pkg::FRAME_BYTES_DEF,
    parameter int LEVEL_MAX     = frp_pkg::LEVEL_MAX_DEF,
    parameter int REPEAT_FRAMES = frp_pkg::REPEAT_FRAMES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        opcode,
    input  logic [4:0]  channel,
    input  logic [15:0] level,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  data_byte,
    output logic        last_byte
);

    import frp_pkg::*;

    localparam int BYTE_AW = $clog2(FRAME_BYTES);

    state_t             state_reg, state_next;
    logic [1:0]         pending_reg, pending_next;
    logic [FRAME_BYTES-1:0] vhi_reg, vhi_next;
    logic [FRAME_BYTES-1:0] vlo_reg, vlo_next;
    logic               vhi_q_reg, vlo_q_reg;
    logic               in_beat;
    logic               ch_ok;
    logic               set_beat;
    logic               tick_go;
    wr_ctl_t            wr_ctl;
    wr_port_t           wr;
    rd_ctl_t            rd_ctl;
    logic [BYTE_AW-1:0] waddr;
    logic [3:0]         wdata;
    logic               wr_done;
    logic [BYTE_AW-1:0] rd_addr;
    logic               rd_last;
    logic               frame_done;
    logic [3:0]         dout_hi, dout_lo;

    assign in_beat  = in_valid && !in_stall;
    assign ch_ok    = 7'(channel) < 7'(CHANNELS);
    assign set_beat = in_beat && (opcode == OP_SET) && ch_ok;
    assign tick_go  = in_beat && (opcode == OP_TICK) && (pending_reg != 2'd0);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (set_beat)
                begin
                    state_next = ST_WRITE;
                end
                else if (tick_go)
                begin
                    state_next = ST_PRIME;
                end
            end
            ST_WRITE:
            begin
                if (wr_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_PRIME:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (frame_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb
    begin
        in_stall     = 1'b1;
        out_valid    = 1'b0;
        wr_ctl.load  = 1'b0;
        wr_ctl.run   = 1'b0;
        rd_ctl.prime = 1'b0;
        rd_ctl.emit  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall    = 1'b0;
                wr_ctl.load = set_beat;
            end
            ST_WRITE:
            begin
                wr_ctl.run = 1'b1;
            end
            ST_PRIME:
            begin
                rd_ctl.prime = 1'b1;
            end
            ST_EMIT:
            begin
                out_valid   = 1'b1;
                rd_ctl.emit = 1'b1;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // Pending frame count: rearmed by a write, counted down per frame
    always_comb
    begin
        pending_next = pending_reg;
        if (set_beat)
        begin
            pending_next = 2'(REPEAT_FRAMES);
        end
        else if (frame_done)
        begin
            pending_next = pending_reg - 2'd1;
        end
    end

    // Nibble valid bits: set on write, all cleared after a frame
    always_comb
    begin
        vhi_next = vhi_reg;
        vlo_next = vlo_reg;
        if (frame_done)
        begin
            vhi_next = '0;
            vlo_next = '0;
        end
        else if (wr.en)
        begin
            if (wr.bank)
            begin
                vlo_next[waddr] = 1'b1;
            end
            else
            begin
                vhi_next[waddr] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            pending_reg <= 2'd0;
            vhi_reg     <= '0;
            vlo_reg     <= '0;
            vhi_q_reg   <= 1'b0;
            vlo_q_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            pending_reg <= pending_next;
            vhi_reg     <= vhi_next;
            vlo_reg     <= vlo_next;
            vhi_q_reg   <= vhi_reg[rd_addr];
            vlo_q_reg   <= vlo_reg[rd_addr];
        end
    end

    frp_writer #(
        .CHANNELS    (CHANNELS),
        .FRAME_BYTES (FRAME_BYTES),
        .LEVEL_MAX   (LEVEL_MAX)
    ) u_writer (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (wr_ctl),
        .channel (channel),
        .level   (level),
        .wr      (wr),
        .waddr   (waddr),
        .wdata   (wdata),
        .done    (wr_done)
    );

    frp_reader #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_reader (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (rd_ctl),
        .out_stall (out_stall),
        .rd_addr   (rd_addr),
        .last      (rd_last),
        .done      (frame_done)
    );

    // High-nibble bank
    frp_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (FRAME_BYTES)
    ) u_ram_hi (
        .clk   (clk),
        .we    (wr.en && !wr.bank),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (rd_addr),
        .rdata (dout_hi)
    );

    // Low-nibble bank
    frp_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (FRAME_BYTES)
    ) u_ram_lo (
        .clk   (clk),
        .we    (wr.en && wr.bank),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (rd_addr),
        .rdata (dout_lo)
    );

    // Output beat; unwritten nibbles read as zero
    assign data_byte = {vhi_q_reg ? dout_hi : 4'h0, vlo_q_reg ? dout_lo : 4'h0};
    assign last_byte = rd_last;

    // A frame only streams while frames are pending
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (pending_reg != 2'd0))
        else $error("frame streaming with no frame pending");

    // Input and output sides are never open at once
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> !out_valid)
        else $error("input taken while a frame is streaming");

    // The last beat ends the frame
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && last_byte) |=> (!out_valid && !in_stall))
        else $error("frame did not end after the last beat");

    // Frame store only written during a channel write
    assert property (@(posedge clk) disable iff (!rst_n)
        wr.en |-> (state_reg == ST_WRITE))
        else $error("frame store written outside a channel write");

    // A frame tick with frames pending always leads to a priming cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        tick_go |=> (state_reg == ST_PRIME))
        else $error("pending frame tick did not start a frame");

endmodule
